### hdl/mxts_pkg.sv
package mxts_pkg;

  // store geometry
  localparam int MAX_TAGS       = 256;
  localparam int MAX_CELLS      = 4;
  localparam int WORDS_PER_CELL = 4;
  localparam int GROUP_SIZE     = 8;
  localparam int BUF_WORDS      = MAX_CELLS * WORDS_PER_CELL;
  localparam int STORE_WORDS    = MAX_TAGS * BUF_WORDS;

  // derived widths
  localparam int STORE_AW = $clog2(STORE_WORDS);
  localparam int BUF_AW   = $clog2(BUF_WORDS);
  localparam int WPT_W    = $clog2(BUF_WORDS + 1);
  localparam int CNT_W    = $clog2(STORE_WORDS + 1);
  localparam int TAGS_W   = $clog2(MAX_TAGS + 1);
  localparam int GSEL_W   = $clog2(GROUP_SIZE);

  // field widths
  localparam int WORD_W     = 64;
  localparam int MODE_W     = 2;
  localparam int TAG_IDX_W  = 8;
  localparam int WIDX_W     = 4;
  localparam int GROUP_W    = 5;
  localparam int MASK_W     = 8;
  localparam int STATUS_W   = 2;
  localparam int CELLS_W    = 3;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // command queue
  localparam int FIFO_DEPTH = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TAG_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS     = CFG_IDX_W'(1);

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND,
    MODE_READ,
    MODE_LOAD,
    MODE_XOR
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_BAD_TAG,
    ST_FULL,
    ST_BAD_WORD
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_APPEND,
    OP_READ,
    OP_LOAD,
    OP_XOR
  } op_e;

  // classified command from front to back
  typedef struct packed {
    op_e                  op;
    logic [STORE_AW-1:0]  addr;
    logic [WORD_W-1:0]    data;
    logic [GROUP_W-1:0]   group;
    logic [MASK_W-1:0]    mask;
    logic [WPT_W-1:0]     wpt;
    status_e              status;
    logic [TAGS_W-1:0]    stored;
  } cmd_t;

endpackage

### hdl/mxts_if.sv
interface mxts_in_if;
  logic                             valid;
  logic                             ready;
  logic [mxts_pkg::MODE_W-1:0]      mode;
  logic [mxts_pkg::TAG_IDX_W-1:0]   tag_index;
  logic [mxts_pkg::WIDX_W-1:0]      word_index;
  logic [mxts_pkg::WORD_W-1:0]      data_word;
  logic [mxts_pkg::GROUP_W-1:0]     group_index;
  logic [mxts_pkg::MASK_W-1:0]      select_mask;

  modport source (output valid, mode, tag_index, word_index, data_word, group_index,
                  select_mask, input ready);
  modport sink (input valid, mode, tag_index, word_index, data_word, group_index,
                select_mask, output ready);
endinterface

interface mxts_out_if;
  logic                             valid;
  logic                             ready;
  logic [mxts_pkg::WORD_W-1:0]      read_word;
  logic [mxts_pkg::STATUS_W-1:0]    status;
  logic [mxts_pkg::TAGS_W-1:0]      stored_tags;

  modport source (output valid, read_word, status, stored_tags, input ready);
  modport sink (input valid, read_word, status, stored_tags, output ready);
endinterface

interface mxts_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mxts_pkg::CFG_IDX_W-1:0]   reg_index;
  logic [mxts_pkg::CFG_DATA_W-1:0]  wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

### hdl/masked_xor_tag_store_core.sv
// channel  | dir | handshake     | payload
// ---------+-----+---------------+------------------------------------------------
// in_i     | in  | valid / ready | mode, tag_index, word_index, data_word,
//          |     |               | group_index, select_mask
// out_o    | out | valid / ready | read_word, status, stored_tags
// cfg_i    | in  | valid / ready | reg_index (0 tag_count, 1 cells_per_tag), wdata
//
// the front classifies an item in the cycle of its transfer and queues it (two deep)
// append, load and refused items go to the result register; a read waits
// in S_READ for the registered tag store read port
// selection byte: the walk reads one word per cycle of each selected entry, up to
// 8 entries x 16 words, writing each back through the single tag store write port
// reset clears counters and state, sets 256 tags of 1 cell; tag store not cleared
// a stalled result holds the back end; the front then fills the queue and stops
module masked_xor_tag_store_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  mxts_in_if.sink    in_i,
  mxts_out_if.source out_o,
  mxts_cfg_if.sink   cfg_i
);

  mxts_pkg::cmd_t front_cmd, back_cmd;
  logic           front_valid, front_ready;
  logic           back_valid, back_ready;

  // classify and check
  mxts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_i),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  // command queue between front and back
  mxts_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_cmd),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (back_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  // storage access and results
  mxts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .out_o       (out_o)
  );

endmodule

### hdl/mxts_ram.sv
module mxts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/mxts_front.sv
module mxts_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  mxts_in_if.sink        in_i,
  mxts_cfg_if.sink       cfg_i,
  output mxts_pkg::cmd_t cmd_o,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i
);

  // x / 3 as (x * 683) >> 11, exact for x below 2048
  localparam int DIV3_MUL = 683;
  localparam int DIV3_SH  = 11;
  localparam int QW       = mxts_pkg::CNT_W - 2;

  logic [8:0]                     tag_count_q, tag_count_d;
  logic [mxts_pkg::CELLS_W-1:0]   cells_q, cells_d;
  logic [mxts_pkg::CNT_W-1:0]     words_q, words_d;
  logic [mxts_pkg::TAGS_W-1:0]    stored_q, stored_d;

  logic [mxts_pkg::CELLS_W-1:0]   cells_eff;
  logic [mxts_pkg::WPT_W-1:0]     wpt;
  logic [mxts_pkg::CNT_W-1:0]     cap;
  logic [8:0]                     limit;
  logic [mxts_pkg::CNT_W-1:0]     rd_prod;
  logic [mxts_pkg::MASK_W-1:0]    mask_eff;
  logic [mxts_pkg::TAG_IDX_W-1:0] entry;
  logic                           in_xfer;
  mxts_pkg::mode_e                mode;

  function automatic logic [mxts_pkg::CELLS_W-1:0] eff_cells(
    input logic [mxts_pkg::CELLS_W-1:0] c
  );
    logic [mxts_pkg::CELLS_W-1:0] r;
    r = c;
    if (c == '0) begin
      r = mxts_pkg::CELLS_W'(1);
    end else if (c > mxts_pkg::CELLS_W'(mxts_pkg::MAX_CELLS)) begin
      r = mxts_pkg::CELLS_W'(mxts_pkg::MAX_CELLS);
    end
    return r;
  endfunction

  // complete tags held by a word count, saturated
  function automatic logic [mxts_pkg::TAGS_W-1:0] tags_of(
    input logic [mxts_pkg::CNT_W-1:0]   w,
    input logic [mxts_pkg::CELLS_W-1:0] c
  );
    logic [QW-1:0]        x;
    logic [QW+9:0]        p;
    logic [QW-1:0]        n;
    x = w[mxts_pkg::CNT_W-1:2];
    p = (QW+10)'(x) * (QW+10)'(DIV3_MUL);
    case (c)
      3'd1:    n = x;
      3'd2:    n = x >> 1;
      3'd3:    n = QW'(p >> DIV3_SH);
      default: n = x >> 2;
    endcase
    if (n > QW'(mxts_pkg::MAX_TAGS)) begin
      n = QW'(mxts_pkg::MAX_TAGS);
    end
    return mxts_pkg::TAGS_W'(n);
  endfunction

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = cmd_ready_i;
  assign cmd_valid_o = in_i.valid;
  assign in_xfer     = in_i.valid && cmd_ready_i;
  assign mode        = mxts_pkg::mode_e'(in_i.mode);

  // effective configuration
  assign cells_eff = eff_cells(cells_q);
  assign wpt       = mxts_pkg::WPT_W'({cells_eff, 2'b00});
  assign cap       = mxts_pkg::CNT_W'(wpt) << $clog2(mxts_pkg::MAX_TAGS);
  assign limit     = (tag_count_q > 9'(mxts_pkg::MAX_TAGS)) ? 9'(mxts_pkg::MAX_TAGS)
                                                             : tag_count_q;
  assign rd_prod   = mxts_pkg::CNT_W'(in_i.tag_index) * mxts_pkg::CNT_W'(wpt);

  // selection byte restricted to entries below the tag count
  always_comb begin
    mask_eff = '0;
    entry    = '0;
    for (int j = 0; j < mxts_pkg::GROUP_SIZE; j++) begin
      entry = {in_i.group_index, mxts_pkg::GSEL_W'(j)};
      mask_eff[j] = in_i.select_mask[j] && ({1'b0, entry} < limit);
    end
  end

  // classify the item
  always_comb begin
    words_d       = words_q;
    cmd_o         = '0;
    cmd_o.op      = mxts_pkg::OP_NONE;
    cmd_o.status  = mxts_pkg::ST_OK;
    cmd_o.data    = in_i.data_word;
    cmd_o.group   = in_i.group_index;
    cmd_o.wpt     = wpt;
    case (mode)
      mxts_pkg::MODE_APPEND: begin
        if (words_q >= cap) begin
          cmd_o.status = mxts_pkg::ST_FULL;
        end else begin
          cmd_o.op   = mxts_pkg::OP_APPEND;
          cmd_o.addr = words_q[mxts_pkg::STORE_AW-1:0];
          if (in_xfer) begin
            words_d = words_q + 1'b1;
          end
        end
      end
      mxts_pkg::MODE_READ: begin
        if ({1'b0, in_i.tag_index} >= stored_q) begin
          cmd_o.status = mxts_pkg::ST_BAD_TAG;
        end else if (mxts_pkg::WPT_W'(in_i.word_index) >= wpt) begin
          cmd_o.status = mxts_pkg::ST_BAD_WORD;
        end else begin
          cmd_o.op   = mxts_pkg::OP_READ;
          cmd_o.addr = mxts_pkg::STORE_AW'(rd_prod + mxts_pkg::CNT_W'(in_i.word_index));
        end
      end
      mxts_pkg::MODE_LOAD: begin
        if (mxts_pkg::WPT_W'(in_i.word_index) >= wpt) begin
          cmd_o.status = mxts_pkg::ST_BAD_WORD;
        end else begin
          cmd_o.op   = mxts_pkg::OP_LOAD;
          cmd_o.addr = mxts_pkg::STORE_AW'(in_i.word_index);
        end
      end
      mxts_pkg::MODE_XOR: begin
        cmd_o.op   = mxts_pkg::OP_XOR;
        cmd_o.mask = mask_eff;
      end
      default: begin
        cmd_o.op = mxts_pkg::OP_NONE;
      end
    endcase
    cmd_o.stored = stored_d;
  end

  // configuration writes
  always_comb begin
    tag_count_d = tag_count_q;
    cells_d     = cells_q;
    if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        mxts_pkg::CFG_TAG_COUNT: tag_count_d = cfg_i.wdata[8:0];
        mxts_pkg::CFG_CELLS:     cells_d     = cfg_i.wdata[mxts_pkg::CELLS_W-1:0];
        default: begin
          tag_count_d = tag_count_q;
        end
      endcase
    end
  end

  // stored tag count tracks the word count and tag size
  assign stored_d = tags_of(words_d, eff_cells(cells_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_count_q <= 9'(mxts_pkg::MAX_TAGS);
      cells_q     <= mxts_pkg::CELLS_W'(1);
      words_q     <= '0;
      stored_q    <= '0;
    end else begin
      tag_count_q <= tag_count_d;
      cells_q     <= cells_d;
      words_q     <= words_d;
      stored_q    <= stored_d;
    end
  end

endmodule

### hdl/mxts_fifo.sv
module mxts_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mxts_pkg::cmd_t push_data_i,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  output mxts_pkg::cmd_t pop_data_o,
  output logic           pop_valid_o,
  input  logic           pop_ready_i
);

  localparam int PW = $clog2(mxts_pkg::FIFO_DEPTH);
  localparam int CW = $clog2(mxts_pkg::FIFO_DEPTH + 1);

  mxts_pkg::cmd_t  slot_q [mxts_pkg::FIFO_DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != CW'(mxts_pkg::FIFO_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // storage slots
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(mxts_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(mxts_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (count_q != '0))
    else $error("queue empty right after a push");

endmodule

### hdl/mxts_back.sv
module mxts_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mxts_pkg::cmd_t cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  mxts_out_if.source     out_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_XOR,
    S_FIN
  } state_e;

  state_e                          state_q;
  mxts_pkg::cmd_t                  cmd_q;
  logic [mxts_pkg::GSEL_W-1:0]     ent_q;
  logic [mxts_pkg::BUF_AW-1:0]     word_q;
  logic [mxts_pkg::MASK_W-1:0]     left_q;
  logic                            wr_pend_q;
  logic [mxts_pkg::STORE_AW-1:0]   wr_addr_q;
  logic                            res_valid_q;
  logic [mxts_pkg::WORD_W-1:0]     res_word_q;
  mxts_pkg::status_e               res_status_q;
  logic [mxts_pkg::TAGS_W-1:0]     res_stored_q;

  logic                            out_free, pop, takes_later, app_we;
  logic                            res_load;
  logic [mxts_pkg::TAG_IDX_W-1:0]  cur_entry;
  logic [mxts_pkg::STORE_AW:0]     xor_prod;
  logic [mxts_pkg::STORE_AW-1:0]   xor_addr;
  logic                            last_word;
  logic [mxts_pkg::MASK_W-1:0]     rest;
  logic [mxts_pkg::GSEL_W-1:0]     next_ent;

  logic                            st_we, st_re;
  logic [mxts_pkg::STORE_AW-1:0]   st_waddr, st_raddr;
  logic [mxts_pkg::WORD_W-1:0]     st_wdata, st_rdata;
  logic                            buf_we, buf_re;
  logic [mxts_pkg::WORD_W-1:0]     buf_rdata;

  function automatic logic [mxts_pkg::GSEL_W-1:0] lowest(
    input logic [mxts_pkg::MASK_W-1:0] m
  );
    logic [mxts_pkg::GSEL_W-1:0] r;
    r = '0;
    for (int j = mxts_pkg::MASK_W - 1; j >= 0; j--) begin
      if (m[j]) begin
        r = mxts_pkg::GSEL_W'(j);
      end
    end
    return r;
  endfunction

  // output register frees when empty or taken this cycle
  assign out_free    = !res_valid_q || out_o.ready;
  assign takes_later = (cmd_i.op == mxts_pkg::OP_READ) || (cmd_i.op == mxts_pkg::OP_XOR);
  assign cmd_ready_o = (state_q == S_IDLE) && (out_free || takes_later);
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign app_we      = pop && (cmd_i.op == mxts_pkg::OP_APPEND);

  // a new result enters the output register
  assign res_load = (state_q == S_IDLE) ? (pop && !takes_later)
                                        : (((state_q == S_READ) || (state_q == S_FIN))
                                           && out_free);

  // masked update walk: entry by entry, word by word
  assign cur_entry = {cmd_q.group, ent_q};
  assign xor_prod  = (mxts_pkg::STORE_AW+1)'(cur_entry) * (mxts_pkg::STORE_AW+1)'(cmd_q.wpt);
  assign xor_addr  = mxts_pkg::STORE_AW'(xor_prod + (mxts_pkg::STORE_AW+1)'(word_q));
  assign last_word = ((mxts_pkg::WPT_W'(word_q) + 1'b1) == cmd_q.wpt);
  assign rest      = left_q & ~(mxts_pkg::MASK_W'(1) << ent_q);
  assign next_ent  = lowest(rest);

  // tag store ports: appends, reads and the read-modify-write pipeline
  assign st_we    = app_we || wr_pend_q;
  assign st_waddr = wr_pend_q ? wr_addr_q : cmd_i.addr;
  assign st_wdata = wr_pend_q ? (st_rdata ^ buf_rdata) : cmd_i.data;
  assign st_re    = (pop && (cmd_i.op == mxts_pkg::OP_READ)) || (state_q == S_XOR);
  assign st_raddr = (state_q == S_XOR) ? xor_addr : cmd_i.addr;

  // write tag buffer ports
  assign buf_we = pop && (cmd_i.op == mxts_pkg::OP_LOAD);
  assign buf_re = (state_q == S_XOR);

  mxts_ram #(
    .WIDTH (mxts_pkg::WORD_W),
    .DEPTH (mxts_pkg::STORE_WORDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  mxts_ram #(
    .WIDTH (mxts_pkg::WORD_W),
    .DEPTH (mxts_pkg::BUF_WORDS)
  ) u_wbuf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (cmd_i.addr[mxts_pkg::BUF_AW-1:0]),
    .wdata_i (cmd_i.data),
    .re_i    (buf_re),
    .raddr_i (word_q),
    .rdata_o (buf_rdata)
  );

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= '0;
      ent_q        <= '0;
      word_q       <= '0;
      left_q       <= '0;
      wr_pend_q    <= 1'b0;
      wr_addr_q    <= '0;
      res_valid_q  <= 1'b0;
      res_word_q   <= '0;
      res_status_q <= mxts_pkg::ST_OK;
      res_stored_q <= '0;
    end else begin
      wr_pend_q <= (state_q == S_XOR);
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (pop) begin
            cmd_q <= cmd_i;
            case (cmd_i.op)
              mxts_pkg::OP_READ: begin
                state_q <= S_READ;
              end
              mxts_pkg::OP_XOR: begin
                ent_q  <= lowest(cmd_i.mask);
                word_q <= '0;
                left_q <= cmd_i.mask;
                state_q <= (cmd_i.mask == '0) ? S_FIN : S_XOR;
              end
              default: begin
                res_word_q   <= '0;
                res_status_q <= cmd_i.status;
                res_stored_q <= cmd_i.stored;
              end
            endcase
          end
        end
        S_READ: begin
          if (out_free) begin
            res_word_q   <= st_rdata;
            res_status_q <= cmd_q.status;
            res_stored_q <= cmd_q.stored;
            state_q      <= S_IDLE;
          end
        end
        S_XOR: begin
          wr_addr_q <= xor_addr;
          if (last_word) begin
            word_q <= '0;
            left_q <= rest;
            ent_q  <= next_ent;
            if (rest == '0) begin
              state_q <= S_FIN;
            end
          end else begin
            word_q <= word_q + 1'b1;
          end
        end
        S_FIN: begin
          if (out_free) begin
            res_word_q   <= '0;
            res_status_q <= cmd_q.status;
            res_stored_q <= cmd_q.stored;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid       = res_valid_q;
  assign out_o.read_word   = res_word_q;
  assign out_o.status      = res_status_q;
  assign out_o.stored_tags = res_stored_q;

  a_wb_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q |-> (state_q == S_XOR || state_q == S_FIN))
    else $error("write-back pending outside the masked update");

  a_no_port_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_pend_q && app_we))
    else $error("append collides with a write-back");

  a_append_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    app_we |=> (res_valid_q && state_q == S_IDLE))
    else $error("append gave no result");

endmodule
